### design/mcr_pkg.sv
// Package for the multiset combination ranker: beat types, widths,
// register index codes and the Pascal table of binomial coefficients.
// No dependencies.
`default_nettype none

package mcr_pkg;

  localparam int POINTS    = 6;
  localparam int MAX_ITEMS = 15;
  localparam int LANES     = 6;
  localparam int CNT_W     = 4;
  localparam int N_W       = 3;
  localparam int SUF_W     = 4;
  localparam int TOT_W     = 7;
  localparam int POS_W     = 5;
  localparam int K_W       = 3;
  localparam int RANK_W    = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [N_W-1:0] POINTS_RESET = N_W'(6);
  localparam logic [N_W-1:0] N_LIMIT      = N_W'(POINTS < LANES ? POINTS : LANES);

  // word index of each configuration register
  localparam logic CFG_IDX_POINTS_IN_USE = 1'b0;

  typedef struct packed {
    logic [CNT_W-1:0] count_0;
    logic [CNT_W-1:0] count_1;
    logic [CNT_W-1:0] count_2;
    logic [CNT_W-1:0] count_3;
    logic [CNT_W-1:0] count_4;
    logic [CNT_W-1:0] count_5;
  } in_beat_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              overfull;
  } out_beat_t;

  typedef logic [LANES-1:0][SUF_W-1:0]  suf_vec_t;
  typedef logic [LANES-1:0][RANK_W-1:0] term_vec_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic           overfull;
    suf_vec_t       suf;
  } prep_t;

  typedef logic [(1<<K_W)-1:0][RANK_W-1:0] binom_row_t;
  typedef binom_row_t [(1<<POS_W)-1:0]     binom_tbl_t;

  // Pascal recurrence, evaluated at elaboration
  function automatic binom_tbl_t build_binom();
    binom_tbl_t t;
    t = '0;
    for (int p = 0; p < (1 << POS_W); p++) begin
      for (int k = 0; k < (1 << K_W); k++) begin
        if (k == 0) begin
          t[p][k] = RANK_W'(1);
        end else if (p == 0) begin
          t[p][k] = '0;
        end else begin
          t[p][k] = t[p-1][k] + t[p-1][k-1];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tbl_t BINOM_TBL = build_binom();

endpackage

`default_nettype wire

### design/mcr_prep.sv
// Front stage of the ranker: masks unused counts, forms suffix sums
// and the overfull flag. Depends on mcr_pkg.
`default_nettype none

module mcr_prep import mcr_pkg::*; (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire in_beat_t       in_data,
  input  wire logic [N_W-1:0] points_cfg,
  output prep_t               prep_r
);

  logic [LANES-1:0][CNT_W-1:0] cnt;
  logic [LANES-1:0][CNT_W-1:0] cnt_m;
  logic [N_W-1:0]              n_eff;
  logic [TOT_W-1:0]            acc;
  prep_t                       prep_nxt;

  always_comb begin
    cnt[0] = in_data.count_0;
    cnt[1] = in_data.count_1;
    cnt[2] = in_data.count_2;
    cnt[3] = in_data.count_3;
    cnt[4] = in_data.count_4;
    cnt[5] = in_data.count_5;

    if (points_cfg == '0) begin
      n_eff = N_W'(1);
    end else if (points_cfg > N_LIMIT) begin
      n_eff = N_LIMIT;
    end else begin
      n_eff = points_cfg;
    end

    acc = '0;
    prep_nxt.suf = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      cnt_m[i] = (N_W'(i) < n_eff) ? cnt[i] : '0;
      acc = acc + TOT_W'(cnt_m[i]);
      prep_nxt.suf[i] = acc[SUF_W-1:0];
    end
    prep_nxt.n        = n_eff;
    prep_nxt.overfull = (acc > TOT_W'(MAX_ITEMS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mcr_lane.sv
// One ranking lane: position of its set bit and the binomial term
// looked up from the Pascal table. Depends on mcr_pkg.
`default_nettype none

module mcr_lane import mcr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [N_W-1:0]   lane_idx,
  input  wire logic [N_W-1:0]   n,
  input  wire logic [SUF_W-1:0] suf,
  output logic [RANK_W-1:0]     term_r
);

  logic              active;
  logic [POS_W-1:0]  pos;
  logic [K_W-1:0]    k;
  logic [RANK_W-1:0] term_nxt;

  always_comb begin
    active   = (lane_idx < n);
    pos      = POS_W'(n) - POS_W'(1) - POS_W'(lane_idx) + POS_W'(suf);
    k        = K_W'(n - lane_idx);
    term_nxt = active ? BINOM_TBL[pos][k] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mcr_merge.sv
// Merge stage: adds the lane terms and holds the result beat in the
// output register. Depends on mcr_pkg.
`default_nettype none

module mcr_merge import mcr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire logic      valid_in,
  input  wire logic      overfull_in,
  input  wire term_vec_t terms,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_beat_t      out_data
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  out_beat_t         out_data_r;
  out_beat_t         out_data_nxt;
  logic [RANK_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + terms[i];
    end
    out_data_nxt.rank     = overfull_in ? '0 : sum;
    out_data_nxt.overfull = overfull_in;

    if (load) begin
      out_valid_nxt = valid_in;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/multiset_combination_rank.sv
// Multiset combination ranker, top level. Takes one beat per cycle when not
// stalled and returns each result beat through a suffix-sum stage, six
// table-lookup lanes and an adder merge feeding the output register. The
// pipeline stalls only when the output register is full and not taken;
// bubbles ahead of it still fill. points_in_use is set over an APB port.
// Depends on mcr_pkg, mcr_prep, mcr_lane, mcr_merge.
`default_nettype none

module multiset_combination_rank import mcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [N_W-1:0] points_r;
  logic           v_a_r;
  logic           v_b_r;
  logic           ovf_b_r;
  logic           en_a;
  logic           en_b;
  logic           en_c;
  prep_t          prep;
  term_vec_t      terms;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= POINTS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1] == CFG_IDX_POINTS_IN_USE)) begin
      points_r <= pwdata[N_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == CFG_IDX_POINTS_IN_USE) ?
                  DATA_W'(points_r) : '0;

  // stage enables
  assign en_c     = !out_valid || out_ready;
  assign en_b     = !v_b_r || en_c;
  assign en_a     = !v_a_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else begin
      if (en_a) begin
        v_a_r <= in_valid;
      end
      if (en_b) begin
        v_b_r <= v_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      ovf_b_r <= prep.overfull;
    end
  end

  mcr_prep u_prep (
    .clk        (clk),
    .en         (en_a),
    .in_data    (in_data),
    .points_cfg (points_r),
    .prep_r     (prep)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mcr_lane u_lane (
      .clk      (clk),
      .en       (en_b),
      .lane_idx (N_W'(i)),
      .n        (prep.n),
      .suf      (prep.suf[i]),
      .term_r   (terms[i])
    );
  end

  mcr_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (en_c),
    .valid_in    (v_b_r),
    .overfull_in (ovf_b_r),
    .terms       (terms),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### design/mcr_checker.sv
// Port-level checks for the multiset combination ranker, bound to the
// top level. Depends on mcr_pkg and multiset_combination_rank.
`default_nettype none

module mcr_checker import mcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_ready,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire out_beat_t         out_data
);

  a_overfull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overfull |-> out_data.rank == '0)
    else $error("overfull beat with nonzero rank");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overfull |-> out_data.rank < RANK_W'(54264))
    else $error("rank out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

endmodule

bind multiset_combination_rank mcr_checker u_mcr_checker (.*);

`default_nettype wire

### dv/multiset_combination_rank_tb.sv
// Testbench for multiset_combination_rank: count beats go in over valid/ready, and each
// result beat is checked against a local stars-and-bars rank predictor.
// Depends on mcr_pkg and the multiset_combination_rank RTL.
`default_nettype none

module multiset_combination_rank_tb;
  import mcr_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_beat_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  in_beat_t  count_beats[$];
  out_beat_t expected_ranks[$];
  logic [N_W-1:0] points_cfg;
  logic      in_fire;
  logic      out_fire;
  int        in_gap_max;
  int        out_stall_max;
  int        in_gap;
  int        out_stall;
  int        errors;
  int        cfg_errors;

  multiset_combination_rank uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  function automatic int live_points(logic [N_W-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n == 0) n = 1;
    if (n > POINTS) n = POINTS;
    if (n > LANES) n = LANES;
    return n;
  endfunction

  function automatic longint choose(int p, int k);
    longint r;
    r = 1;
    if (p < 0 || k > p) return 0;
    for (int i = 1; i <= k; i++) r = r * (p - k + i) / i;
    return r;
  endfunction

  function automatic out_beat_t rank_of_counts(in_beat_t b, logic [N_W-1:0] cfg);
    int        c[LANES];
    int        n;
    int        total;
    int        pos;
    longint    acc;
    out_beat_t res;
    c[0] = b.count_0; c[1] = b.count_1; c[2] = b.count_2;
    c[3] = b.count_3; c[4] = b.count_4; c[5] = b.count_5;
    n = live_points(cfg);
    total = 0;
    acc = 0;
    res = '0;
    for (int i = 0; i < n; i++) total += c[i];
    if (total > MAX_ITEMS) begin
      res.overfull = 1'b1;
      return res;
    end
    // top set bit at n-1+total; each next one sits count+1 below
    pos = n - 1 + total;
    for (int i = 0; i < n; i++) begin
      acc += choose(pos, n - i);
      if (i + 1 < n) pos -= c[i] + 1;
    end
    res.rank = acc[RANK_W-1:0];
    return res;
  endfunction

  function automatic in_beat_t pack_counts(int c[LANES]);
    in_beat_t b;
    b.count_0 = CNT_W'(c[0]); b.count_1 = CNT_W'(c[1]); b.count_2 = CNT_W'(c[2]);
    b.count_3 = CNT_W'(c[3]); b.count_4 = CNT_W'(c[4]); b.count_5 = CNT_W'(c[5]);
    return b;
  endfunction

  task automatic push_counts(int c0, int c1, int c2, int c3, int c4, int c5);
    int c[LANES];
    c = '{c0, c1, c2, c3, c4, c5};
    count_beats.push_back(pack_counts(c));
  endtask

  // mostly legal totals spread over the live points, some boundary and raw noise
  task automatic push_random_counts();
    int c[LANES];
    int n;
    int stars;
    int kind;
    int p;
    n = live_points(points_cfg);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < LANES; i++) c[i] = $urandom_range(0, 15);
    if (kind < 8) begin
      stars = (kind < 6) ? $urandom_range(0, MAX_ITEMS) : $urandom_range(MAX_ITEMS, MAX_ITEMS + 1);
      if (stars > 15 * n) stars = 15 * n;
      for (int i = 0; i < n; i++) c[i] = 0;
      for (int s = 0; s < stars; s++) begin
        p = $urandom_range(0, n - 1);
        while (c[p] == 15) p = (p + 1) % n;
        c[p]++;
      end
    end
    count_beats.push_back(pack_counts(c));
  endtask

  task automatic write_points(logic [N_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * CFG_IDX_POINTS_IN_USE); pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    points_cfg = v;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_W'(v)) begin
      $error("prdata: expected %0d, got %0d", v, prdata);
      cfg_errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (count_beats.size() != 0 || in_valid);
    while (expected_ranks.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (count_beats.size() != 0) begin
        in_data <= count_beats.pop_front();
        in_valid <= 1'b1;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (out_fire) out_stall = $urandom_range(0, out_stall_max);
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_beat_t want;
    in_fire <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_ranks.push_back(rank_of_counts(in_data, points_cfg));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        $error("result beat with nothing expected: rank %0d overfull %0d",
               out_data.rank, out_data.overfull);
        errors++;
      end else begin
        want = expected_ranks.pop_front();
        if (out_data.rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_data.rank);
          errors++;
        end
        if (out_data.overfull !== want.overfull) begin
          $error("overfull: expected %0d, got %0d", want.overfull, out_data.overfull);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [N_W-1:0] cfg;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_gap_max = 3;
    out_stall_max = 3;
    points_cfg = POINTS_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: six points
    push_counts(0, 0, 0, 0, 0, 0);
    push_counts(15, 15, 15, 15, 15, 15);
    push_counts(15, 0, 0, 0, 0, 0);
    push_counts(0, 0, 0, 0, 0, 15);
    push_counts(1, 2, 3, 4, 5, 0);
    push_counts(1, 2, 3, 4, 5, 1);
    push_counts(10, 5, 10, 5, 10, 5);
    push_counts(0, 5, 0, 5, 0, 5);
    wait_drained();

    // zero behaves as one point; other counts ignored
    write_points(3'd0);
    @(posedge clk);
    push_counts(0, 15, 15, 15, 15, 15);
    push_counts(15, 15, 15, 15, 15, 15);
    push_counts(7, 0, 0, 0, 0, 0);
    wait_drained();

    // seven saturates to six
    write_points(3'd7);
    @(posedge clk);
    push_counts(0, 0, 0, 0, 0, 0);
    push_counts(3, 2, 2, 2, 3, 3);
    push_counts(3, 2, 2, 2, 3, 4);
    push_counts(0, 0, 0, 0, 15, 0);
    wait_drained();

    // two points: overfull with a trailing count ignored
    write_points(3'd2);
    @(posedge clk);
    push_counts(8, 8, 15, 15, 15, 15);
    push_counts(0, 15, 15, 15, 15, 15);
    push_counts(15, 0, 0, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 16; ph++) begin
      cfg = (ph < 8) ? N_W'(ph == 7 ? 0 : ph + 1) : N_W'($urandom_range(0, 7));
      if (ph == 8) cfg = 3'd7;
      write_points(cfg);
      if (ph == 0) begin
        in_gap_max = 0;
        out_stall_max = 0;
      end else if (ph == 1) begin
        in_gap_max = 9;
        out_stall_max = 9;
      end else begin
        in_gap_max = $urandom_range(0, 1) ? 9 : 0;
        out_stall_max = $urandom_range(0, 1) ? 9 : 0;
      end
      @(posedge clk);
      repeat (90) push_random_counts();
      wait_drained();
    end

    if (errors == 0 && cfg_errors == 0) begin
      $display("multiset_combination_rank_tb passed");
    end else begin
      $display("multiset_combination_rank_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("multiset_combination_rank_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/mcr_pkg.sv
design/mcr_prep.sv
design/mcr_lane.sv
design/mcr_merge.sv
design/multiset_combination_rank.sv
design/mcr_checker.sv
dv/multiset_combination_rank_tb.sv
